/* sv/pmst_pkg.sv */
`timescale 1ns / 1ps
package pmst_pkg;

   localparam int WEIGHT_W  = 16;
   localparam int PARENT_W  = 5;
   localparam int VIDX_W    = 4;
   localparam int COUNT_W   = 5;
   localparam int ENTRY_W   = PARENT_W + WEIGHT_W;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   typedef logic signed [WEIGHT_W-1:0] key_type;
   typedef logic signed [PARENT_W-1:0] parent_type;

   localparam key_type    KEY_INF   = 16'sh7fff;
   localparam parent_type NO_PARENT = 5'sh1f;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_ADD   = 2'd1,
      OP_RUN   = 2'd2
   } op_type;

endpackage

/* sv/pmst_ram.sv */
`timescale 1ns / 1ps
module pmst_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/prim_minimum_spanning_tree_unit.sv */
`timescale 1ns / 1ps
// Prim minimum spanning tree engine. Edges are loaded one beat at a time into an
// adjacency memory (duplicates keep the lower weight), a clear beat empties it by
// zeroing the edge valid bits, and a run beat grows the tree from the start vertex
// and then returns one beat per vertex 1 .. n-1, n being the count held to 1 .. 16,
// with its parent and key. An add-edge beat passes through read, compare and write,
// and mirrored write; a clear needs no further state. A run with n vertices takes up
// to n rounds, each a selection scan and a relaxation scan through the key memory's
// single read port; each result beat then takes a read state and a load state.
// There is no clearing pass after reset; the edge valid bits are flip-flops.
module prim_minimum_spanning_tree_unit #(
   parameter int MAX_VERTICES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // tdata: vertex_a[3:0], vertex_b[7:4], edge_weight[23:8]
   input  logic [pmst_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: operation[1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // tdata: vertex_index[3:0], parent_vertex[8:4], edge_key[24:9], zero fill
   output logic [pmst_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pmst_pkg::COUNT_W-1:0]    csr_data
);
   import pmst_pkg::*;

   localparam int LIMIT = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
   localparam int IW    = $clog2(LIMIT);
   localparam int CW    = IW + 1;
   localparam int SIZE  = LIMIT * LIMIT;
   localparam int AW    = $clog2(SIZE);

   typedef enum logic [2:0] {
      ST_IDLE, ST_ADD_CMP, ST_ADD_WB, ST_SEL, ST_RELAX, ST_OUT_RD, ST_OUT_LD
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [SIZE-1:0]    pres_ff, pres_in;
   logic [LIMIT-1:0]   reached_ff, reached_in;
   logic [LIMIT-1:0]   visited_ff, visited_in;
   logic [AW-1:0]      ab_ff, ab_in, ba_ff, ba_in;
   key_type            w_ff, w_in;
   logic               upd_ff, upd_in;
   logic [CW-1:0]      sc_ff, sc_in;
   logic               pend_ff, pend_in;
   logic [IW-1:0]      pidx_ff, pidx_in;
   logic               prs_ff, prs_in;
   logic               found_ff, found_in;
   key_type            best_ff, best_in;
   logic [IW-1:0]      bu_ff, bu_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VIDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   parent_type         rsp_par_ff, rsp_par_in;
   key_type            rsp_key_ff, rsp_key_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               adj_wr_en, adj_rd_en, key_wr_en, key_rd_en;
   logic [AW-1:0]      adj_wr_addr, adj_rd_addr, relax_addr;
   logic [WEIGHT_W-1:0] adj_wr_data, adj_rd_data;
   logic [IW-1:0]      key_wr_addr, key_rd_addr;
   logic [ENTRY_W-1:0] key_wr_data, key_rd_data;

   logic [COUNT_W-1:0] n_wide;
   logic [CW-1:0]      n;
   logic               req_fire;
   logic [IW-1:0]      ai, bi;
   logic               a_ok, start_ok;
   key_type            req_w, adj_w, ent_key, cur_key;
   parent_type         ent_par;

   pmst_ram #(.WIDTH(WEIGHT_W), .DEPTH(SIZE)) u_adj_ram (
      .clock(clock), .wr_en(adj_wr_en), .wr_addr(adj_wr_addr), .wr_data(adj_wr_data),
      .rd_en(adj_rd_en), .rd_addr(adj_rd_addr), .rd_data(adj_rd_data)
   );

   pmst_ram #(.WIDTH(ENTRY_W), .DEPTH(LIMIT)) u_key_ram (
      .clock(clock), .wr_en(key_wr_en), .wr_addr(key_wr_addr), .wr_data(key_wr_data),
      .rd_en(key_rd_en), .rd_addr(key_rd_addr), .rd_data(key_rd_data)
   );

   always_comb begin
      if (count_ff == '0) begin
         n_wide = COUNT_W'(1);
      end else if (count_ff > COUNT_W'(LIMIT)) begin
         n_wide = COUNT_W'(LIMIT);
      end else begin
         n_wide = count_ff;
      end
   end
   assign n = CW'(n_wide);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign ai         = IW'(req_tdata[3:0]);
   assign bi         = IW'(req_tdata[7:4]);
   assign req_w      = $signed(req_tdata[23:8]);
   assign a_ok       = (COUNT_W'(req_tdata[3:0]) < COUNT_W'(LIMIT)) &&
                       (COUNT_W'(req_tdata[7:4]) < COUNT_W'(LIMIT));
   assign start_ok   = COUNT_W'(req_tdata[3:0]) < n_wide;
   assign adj_w      = $signed(adj_rd_data);
   assign ent_key    = $signed(key_rd_data[WEIGHT_W-1:0]);
   assign ent_par    = $signed(key_rd_data[ENTRY_W-1:WEIGHT_W]);
   assign cur_key    = reached_ff[pidx_ff] ? ent_key : KEY_INF;
   assign relax_addr = AW'(bu_ff) * AW'(LIMIT) + AW'(sc_ff[IW-1:0]);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pres_in      = pres_ff;
      reached_in   = reached_ff;
      visited_in   = visited_ff;
      ab_in        = ab_ff;
      ba_in        = ba_ff;
      w_in         = w_ff;
      upd_in       = upd_ff;
      sc_in        = sc_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      prs_in       = prs_ff;
      found_in     = found_ff;
      best_in      = best_ff;
      bu_in        = bu_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_par_in   = rsp_par_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_last_in  = rsp_last_ff;
      adj_wr_en    = 1'b0;
      adj_wr_addr  = ab_ff;
      adj_wr_data  = w_ff;
      adj_rd_en    = 1'b0;
      adj_rd_addr  = relax_addr;
      key_wr_en    = 1'b0;
      key_wr_addr  = pidx_ff;
      key_wr_data  = {PARENT_W'(bu_ff), adj_rd_data};
      key_rd_en    = 1'b0;
      key_rd_addr  = sc_ff[IW-1:0];

      if (csr_valid) begin
         count_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_tuser)
                  OP_CLEAR: begin
                     pres_in = '0;
                  end
                  OP_ADD: begin
                     if (a_ok) begin
                        ab_in       = AW'(ai) * AW'(LIMIT) + AW'(bi);
                        ba_in       = AW'(bi) * AW'(LIMIT) + AW'(ai);
                        w_in        = req_w;
                        adj_rd_en   = 1'b1;
                        adj_rd_addr = AW'(ai) * AW'(LIMIT) + AW'(bi);
                        state_in    = ST_ADD_CMP;
                     end
                  end
                  OP_RUN: begin
                     reached_in = '0;
                     visited_in = '0;
                     if (start_ok) begin
                        key_wr_en       = 1'b1;
                        key_wr_addr     = ai;
                        key_wr_data     = {NO_PARENT, {WEIGHT_W{1'b0}}};
                        reached_in[ai]  = 1'b1;
                     end
                     sc_in    = '0;
                     pend_in  = 1'b0;
                     found_in = 1'b0;
                     state_in = ST_SEL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ADD_CMP: begin
            upd_in = !pres_ff[ab_ff] || (w_ff < adj_w);
            if (upd_in) begin
               adj_wr_en      = 1'b1;
               pres_in[ab_ff] = 1'b1;
            end
            state_in = ST_ADD_WB;
         end
         ST_ADD_WB: begin
            if (upd_ff) begin
               adj_wr_en      = 1'b1;
               adj_wr_addr    = ba_ff;
               pres_in[ba_ff] = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_SEL: begin
            pend_in = 1'b0;
            if (sc_ff < n) begin
               key_rd_en = 1'b1;
               pend_in   = 1'b1;
               pidx_in   = sc_ff[IW-1:0];
               sc_in     = sc_ff + CW'(1);
            end
            if (pend_ff && reached_ff[pidx_ff] && !visited_ff[pidx_ff] &&
                (!found_ff || ent_key < best_ff)) begin
               found_in = 1'b1;
               best_in  = ent_key;
               bu_in    = pidx_ff;
            end
            if (sc_ff == n && !pend_ff) begin
               if (found_ff) begin
                  visited_in[bu_ff] = 1'b1;
                  sc_in             = '0;
                  state_in          = ST_RELAX;
               end else begin
                  sc_in    = CW'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         ST_RELAX: begin
            pend_in = 1'b0;
            if (sc_ff < n) begin
               key_rd_en = 1'b1;
               adj_rd_en = 1'b1;
               prs_in    = pres_ff[relax_addr];
               pend_in   = 1'b1;
               pidx_in   = sc_ff[IW-1:0];
               sc_in     = sc_ff + CW'(1);
            end
            if (pend_ff && prs_ff && !visited_ff[pidx_ff] && (adj_w < cur_key)) begin
               key_wr_en           = 1'b1;
               reached_in[pidx_ff] = 1'b1;
            end
            if (sc_ff == n && !pend_ff) begin
               sc_in    = '0;
               found_in = 1'b0;
               state_in = ST_SEL;
            end
         end
         ST_OUT_RD: begin
            if (sc_ff < n) begin
               key_rd_en = 1'b1;
               pidx_in   = sc_ff[IW-1:0];
               state_in  = ST_OUT_LD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT_LD: begin
            // The read data holds while the previous result beat is still pending.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = VIDX_W'(pidx_ff);
               rsp_par_in   = reached_ff[pidx_ff] ? ent_par : NO_PARENT;
               rsp_key_in   = cur_key;
               rsp_last_in  = (sc_ff + CW'(1)) == n;
               sc_in        = sc_ff + CW'(1);
               state_in     = ST_OUT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= COUNT_RESET;
         pres_ff      <= '0;
         reached_ff   <= '0;
         visited_ff   <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pres_ff      <= pres_in;
         reached_ff   <= reached_in;
         visited_ff   <= visited_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ab_ff       <= ab_in;
      ba_ff       <= ba_in;
      w_ff        <= w_in;
      upd_ff      <= upd_in;
      sc_ff       <= sc_in;
      pidx_ff     <= pidx_in;
      prs_ff      <= prs_in;
      best_ff     <= best_in;
      bu_ff       <= bu_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_par_ff  <= rsp_par_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_key_ff, rsp_par_ff, rsp_idx_ff};

   a_visited_reached: assert property (@(posedge clock) disable iff (reset)
      (visited_ff & ~reached_ff) == '0)
      else $error("a visited vertex was never reached");

   a_best_reached: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RELAX) |-> (reached_ff[bu_ff] && visited_ff[bu_ff]))
      else $error("relaxation from a vertex that is not in the tree");

   a_pend_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_SEL || state_ff == ST_RELAX || state_ff == ST_IDLE))
      else $error("memory read pending outside a scan");

endmodule

/* bench/prim_minimum_spanning_tree_unit_tb.sv */
`timescale 1ns / 1ps
module prim_minimum_spanning_tree_unit_tb;
   import pmst_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam int DRAIN_CYCLES   = 50;
   localparam int LONG_HOLD      = 3000;
   localparam op_type OP_SPARE   = op_type'(2'd3);

   typedef struct packed {
      op_type                opcode;
      logic [3:0]            va;
      logic [3:0]            vb;
      logic signed [15:0]    wt;
   } edge_req_type;

   typedef struct packed {
      logic [3:0]         vidx;
      logic signed [4:0]  par;
      logic signed [15:0] key;
      logic               lst;
   } tree_edge_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [COUNT_W-1:0] csr_data = '0;

   prim_minimum_spanning_tree_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: the graph as the block should hold it.
   logic [15:0]        graph_present_rows [16];
   logic signed [15:0] graph_weight [16][16];
   logic [4:0]         vertex_total;

   edge_req_type  pending_reqs [$];
   tree_edge_type expected_edges [$];
   int   error_count = 0;
   int   idle_cycles = 0;
   int   hold_count = 0;
   bit   stall_long = 1'b0;
   bit   sender_hold = 1'b0;
   int   burst_left = 0;
   int   gap_left = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      error_count++;
   endtask

   function automatic void predict_tree(input edge_req_type r);
      int n;
      int sel;
      logic signed [15:0] key [16];
      int par [16];
      bit seen [16];
      bit done [16];
      tree_edge_type t;
      n = (vertex_total == 0) ? 1 : (vertex_total > 16 ? 16 : vertex_total);
      for (int v = 0; v < 16; v++) begin
         key[v] = 16'sh7fff; par[v] = -1; seen[v] = 0; done[v] = 0;
      end
      if (r.va < n) begin
         key[r.va] = 0;
         seen[r.va] = 1;
         forever begin
            sel = n;
            for (int v = 0; v < n; v++)
               if (seen[v] && !done[v] && (sel == n || key[v] < key[sel])) sel = v;
            if (sel == n) break;
            done[sel] = 1;
            for (int v = 0; v < n; v++)
               if (graph_present_rows[sel][v] && !done[v] && graph_weight[sel][v] < key[v]) begin
                  key[v] = graph_weight[sel][v];
                  par[v] = sel;
                  seen[v] = 1;
               end
         end
      end
      for (int v = 1; v < n; v++) begin
         t.vidx = v[3:0];
         t.par = par[v][4:0];
         t.key = key[v];
         t.lst = (v + 1 == n);
         expected_edges = {expected_edges, t};
      end
   endfunction

   function automatic void apply_request(input edge_req_type r);
      case (r.opcode)
         OP_CLEAR: begin
            for (int i = 0; i < 16; i++) graph_present_rows[i] = '0;
         end
         OP_ADD: begin
            if (!graph_present_rows[r.va][r.vb] || r.wt < graph_weight[r.va][r.vb]) begin
               graph_weight[r.va][r.vb] = r.wt;
               graph_present_rows[r.va][r.vb] = 1'b1;
            end
            if (!graph_present_rows[r.vb][r.va] || r.wt < graph_weight[r.vb][r.va]) begin
               graph_weight[r.vb][r.va] = r.wt;
               graph_present_rows[r.vb][r.va] = 1'b1;
            end
         end
         OP_RUN: predict_tree(r);
         default: ;
      endcase
   endfunction

   // Driver: bursts with random gaps, holding off entirely while sender_hold is set.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            apply_request(pending_reqs.pop_front());
         end
         if ((!req_tvalid || req_tready)) begin
            if (gap_left > 0) gap_left <= gap_left - 1;
            if (!sender_hold && gap_left == 0 && pending_reqs.size() > 0 &&
                !(req_tvalid && req_tready && pending_reqs.size() == 0)) begin
               req_tvalid <= 1'b1;
               {req_tuser, req_tdata} <= {pending_reqs[0].opcode, pending_reqs[0].wt,
                                          pending_reqs[0].vb, pending_reqs[0].va};
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall pattern, with one long hold-off counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_long && hold_count < LONG_HOLD) begin
         rsp_tready <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 15) < 11);
      end
   end

   // Monitor.
   always @(posedge clock) begin
      tree_edge_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_edges.size() == 0) begin
            report_mismatch("unexpected beat, vertex", rsp_tdata[3:0], -1);
         end else begin
            want = expected_edges.pop_front();
            if (rsp_tdata[3:0] !== want.vidx)
               report_mismatch("vertex_index", rsp_tdata[3:0], want.vidx);
            if ($signed(rsp_tdata[8:4]) !== want.par)
               report_mismatch("parent_vertex", $signed(rsp_tdata[8:4]), want.par);
            if ($signed(rsp_tdata[24:9]) !== want.key)
               report_mismatch("edge_key", $signed(rsp_tdata[24:9]), want.key);
            if (rsp_tlast !== want.lst)
               report_mismatch("last", rsp_tlast, want.lst);
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[prim_minimum_spanning_tree_unit] ERROR");
         $finish;
      end
   end

   task automatic queue_req(input op_type op, input int a, input int b, input int w);
      edge_req_type r;
      r.opcode = op; r.va = a[3:0]; r.vb = b[3:0]; r.wt = w[15:0];
      pending_reqs = {pending_reqs, r};
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_edges.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value[4:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      vertex_total = value[4:0];
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random_graph(input int n, input int edges);
      queue_req(OP_CLEAR, 0, 0, 0);
      for (int e = 0; e < edges; e++)
         queue_req(OP_ADD, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                   ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40) - 20);
      queue_req(OP_RUN, $urandom_range(0, n), 0, $urandom);
   endtask

   initial begin
      int n;
      vertex_total = COUNT_RESET;
      for (int i = 0; i < 16; i++) graph_present_rows[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset count of sixteen.
      queue_req(OP_RUN, 0, 0, 0);
      queue_req(OP_ADD, 0, 1, -32768);
      queue_req(OP_ADD, 0, 1, 5);
      queue_req(OP_ADD, 1, 2, 32767);
      queue_req(OP_ADD, 3, 3, -7);
      queue_req(OP_ADD, 15, 14, 32766);
      queue_req(OP_ADD, 14, 0, -1);
      queue_req(OP_ADD, 2, 0, 3);
      queue_req(OP_ADD, 2, 1, 3);
      queue_req(OP_SPARE, 5, 10, 1234);
      queue_req(OP_RUN, 0, 15, -1);
      queue_req(OP_RUN, 15, 0, 0);
      queue_req(OP_CLEAR, 15, 15, -1);
      queue_req(OP_RUN, 1, 0, 0);
      wait_drained();

      // Count extremes, and a start vertex beyond the count.
      write_count(1);
      queue_req(OP_ADD, 0, 1, 4);
      queue_req(OP_RUN, 0, 0, 0);
      wait_drained();
      write_count(0);
      queue_req(OP_RUN, 0, 0, 0);
      wait_drained();
      write_count(31);
      queue_req(OP_RUN, 0, 0, 0);
      wait_drained();
      write_count(2);
      queue_req(OP_RUN, 2, 0, 0);
      queue_req(OP_RUN, 1, 0, 0);
      wait_drained();

      // Long receiver hold-off while the sender keeps offering runs.
      write_count(16);
      stall_long = 1'b1;
      for (int k = 0; k < 6; k++) queue_req(OP_RUN, k, 0, 0);
      wait (hold_count == LONG_HOLD);
      stall_long = 1'b0;
      wait_drained();

      // Random graphs at several counts; mostly small, a few full-size.
      for (int g = 0; g < 14; g++) begin
         n = (g % 5 == 4) ? 16 : $urandom_range(2, 8);
         if (g % 3 == 0) begin
            wait_drained();
            write_count((g == 6) ? $urandom_range(17, 31) : n);
            if (g == 6) n = 16;
         end
         queue_random_graph(vertex_total == 0 ? 1 : (vertex_total > 16 ? 16 : vertex_total),
                            $urandom_range(8, 16));
         if (g == 7) begin
            // Sender pauses until every expected beat has come.
            sender_hold = 1'b1;
            while (req_tvalid || expected_edges.size() > 0) @(posedge clock);
            sender_hold = 1'b0;
         end
      end
      wait_drained();

      if (error_count == 0) begin
         $display("[prim_minimum_spanning_tree_unit] OK");
      end else begin
         $display("[prim_minimum_spanning_tree_unit] ERROR");
      end
      $finish;
   end

endmodule
